// ===== hw/rtl/iss_pkg.sv =====
// shared types and constants for the indexed sequence store
// no dependencies; used by iss_ctrl, iss_dp and indexed_sequence_store
`default_nettype none

package iss_pkg;

  // list geometry
  localparam int CAPACITY = 16;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // fixed field widths
  localparam int OP_W   = 3;
  localparam int IDX_W  = 5;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;
  localparam logic [OP_W-1:0] OP_READ       = 3'd6;
  localparam logic [OP_W-1:0] OP_WRITE      = 3'd7;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  // input word
  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [ST_W-1:0]          status;
    logic [CNT_W-1:0]         count;
  } out_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/indexed_sequence_store.sv =====
// indexed sequence store: bounded ordered list of signed words with indexed insert and erase
// input word registered, then executed into the result register when the output has room
// no new word is accepted until its execute step is done (register-then-execute sequence)
// insert and erase shift every slot at or above the position in the single execute step
// reset: synchronous active-low clears the count (list empty); slot contents are not cleared
`default_nettype none

module indexed_sequence_store (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire iss_pkg::in_word_t    in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output iss_pkg::out_word_t        out_word
);

  iss_pkg::dp_cmd_t cmd;

  // sequencing
  iss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // list storage and operation logic
  iss_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .out_word (out_word)
  );

  // busy for the execute cycle after an accepted word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled during execute");

  // count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_word.count) <= 32'(iss_pkg::CAPACITY)))
    else $error("count beyond capacity");

  // full report only with a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == iss_pkg::ST_FULL) |->
      (32'(out_word.count) == 32'(iss_pkg::CAPACITY)))
    else $error("full status with list not full");

  // empty report only with an empty list and zero data
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == iss_pkg::ST_EMPTY) |->
      (out_word.count == '0) && (out_word.data == '0))
    else $error("empty status with elements or data");

endmodule

`default_nettype wire

// ===== hw/rtl/iss_ctrl.sv =====
// sequencing controller: accepts a word, runs one execute step, holds the result valid
// depends on iss_pkg
`default_nettype none

module iss_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output iss_pkg::dp_cmd_t     cmd
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   room;

  // output register free or being emptied this cycle
  assign room = !out_valid_r || !out_stall;

  // commands to the datapath
  always_comb begin
    cmd.load = (state_r == S_IDLE) && in_valid;
    cmd.exec = (state_r == S_EXEC) && room;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // state and result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (room) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iss_dp.sv =====
// datapath: input register, slot register array with one-step shift, count and result register
// depends on iss_pkg
`default_nettype none

module iss_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire iss_pkg::dp_cmd_t     cmd,
  input  wire iss_pkg::in_word_t    in_word,
  output iss_pkg::out_word_t        out_word
);

  iss_pkg::in_word_t              in_r;
  iss_pkg::out_word_t             out_r;
  logic [iss_pkg::DATA_W-1:0]     slots_r   [iss_pkg::CAPACITY];
  logic [iss_pkg::DATA_W-1:0]     slots_nxt [iss_pkg::CAPACITY];
  logic [iss_pkg::LEN_W-1:0]      len_r;
  logic [iss_pkg::LEN_W-1:0]      len_nxt;

  logic [31:0]                    idx_w;
  logic [31:0]                    len_w;
  logic [31:0]                    pos;
  logic [31:0]                    len_nxt_w;
  logic [iss_pkg::SLOT_W-1:0]     pos_s;
  logic                           do_ins;
  logic                           do_del;
  logic                           do_wr;
  logic                           do_rd;
  logic [iss_pkg::ST_W-1:0]       st;
  logic [iss_pkg::DATA_W-1:0]     rd_data;

  assign idx_w = 32'(in_r.index);
  assign len_w = 32'(len_r);

  // operation decode and checks
  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    do_wr  = 1'b0;
    do_rd  = 1'b0;
    pos    = idx_w;
    st     = iss_pkg::ST_OK;
    unique case (in_r.operation) inside
      iss_pkg::OP_PUSH_FRONT, iss_pkg::OP_PUSH_BACK, iss_pkg::OP_INSERT: begin
        if (in_r.operation == iss_pkg::OP_PUSH_FRONT) begin
          pos = 32'd0;
        end else if (in_r.operation == iss_pkg::OP_PUSH_BACK) begin
          pos = len_w;
        end
        if (pos > len_w) begin
          st = iss_pkg::ST_RANGE;
        end else if (len_w >= 32'(iss_pkg::CAPACITY)) begin
          st = iss_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      iss_pkg::OP_POP_FRONT, iss_pkg::OP_POP_BACK: begin
        pos = (in_r.operation == iss_pkg::OP_POP_FRONT) ? 32'd0 : len_w - 32'd1;
        if (len_w == 32'd0) begin
          st = iss_pkg::ST_EMPTY;
        end else begin
          do_del = 1'b1;
        end
      end
      iss_pkg::OP_ERASE: begin
        if (idx_w >= len_w) st = iss_pkg::ST_RANGE;
        else                do_del = 1'b1;
      end
      iss_pkg::OP_READ: begin
        if (idx_w >= len_w) st = iss_pkg::ST_RANGE;
        else                do_rd = 1'b1;
      end
      default: begin
        if (idx_w >= len_w) st = iss_pkg::ST_RANGE;
        else                do_wr = 1'b1;
      end
    endcase
  end

  assign pos_s   = pos[iss_pkg::SLOT_W-1:0];
  assign rd_data = (do_del || do_rd) ? slots_r[pos_s] : '0;

  // per-slot next value: open a gap, close a gap or overwrite
  for (genvar g = 0; g < iss_pkg::CAPACITY; g++) begin : g_slot
    logic [iss_pkg::DATA_W-1:0] below;
    logic [iss_pkg::DATA_W-1:0] above;
    if (g == 0) begin : g_first
      assign below = slots_r[g];
    end else begin : g_rest
      assign below = slots_r[g-1];
    end
    if (g == iss_pkg::CAPACITY - 1) begin : g_last
      assign above = slots_r[g];
    end else begin : g_mid
      assign above = slots_r[g+1];
    end
    always_comb begin
      slots_nxt[g] = slots_r[g];
      if (do_ins) begin
        if (32'(g) > pos)       slots_nxt[g] = below;
        else if (32'(g) == pos) slots_nxt[g] = in_r.value;
      end else if (do_del) begin
        if (32'(g) >= pos) slots_nxt[g] = above;
      end else if (do_wr) begin
        if (32'(g) == pos) slots_nxt[g] = in_r.value;
      end
    end
  end

  // count update
  always_comb begin
    len_nxt = len_r;
    if (do_ins)      len_nxt = len_r + iss_pkg::LEN_W'(1);
    else if (do_del) len_nxt = len_r - iss_pkg::LEN_W'(1);
  end

  assign len_nxt_w = 32'(len_nxt);

  // count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cmd.exec) begin
      len_r <= len_nxt;
    end
  end

  // input word, slots and result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_word;
    end
    if (cmd.exec) begin
      slots_r      <= slots_nxt;
      out_r.data   <= rd_data;
      out_r.status <= st;
      out_r.count  <= len_nxt_w[iss_pkg::CNT_W-1:0];
    end
  end

  assign out_word = out_r;

endmodule

`default_nettype wire
